@@ rtl/core/lcdsw_pkg.sv @@
// Package for the segment LCD serial writer: sizes, frame IDs, opcodes and
// the frame request structure passed from the shadow stage to the serializer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcdsw_pkg;

    // Display memory geometry.
    localparam int RAM_WORDS = 32;
    localparam int SEGMENTS  = 16;
    localparam int COMMONS   = 4;
    localparam int SHADOW_AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

    // Field widths.
    localparam int OPCODE_BITS = 2;
    localparam int ADDR_BITS   = 6;
    localparam int NIB_BITS    = 4;
    localparam int SEG_BITS    = 5;
    localparam int COM_BITS    = 3;
    localparam int CMD_BITS    = 9;
    localparam int ID_BITS     = 3;
    localparam int POS_BITS    = 4;

    // Frame layout.
    localparam int FRAME_BITS = ID_BITS + ADDR_BITS + NIB_BITS;
    localparam logic [ID_BITS-1:0]  ID_WRITE  = 3'b101;
    localparam logic [ID_BITS-1:0]  ID_CMD    = 3'b100;
    localparam logic [POS_BITS-1:0] WRITE_LAST = POS_BITS'(ID_BITS + ADDR_BITS + NIB_BITS - 1);
    localparam logic [POS_BITS-1:0] CMD_LAST   = POS_BITS'(ID_BITS + CMD_BITS - 1);

    // Opcodes.
    localparam logic [OPCODE_BITS-1:0] OP_WRITE_NIBBLE = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_SEGMENT      = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_COMMAND      = 2'd2;

    // Frame request to the serializer; bits[0] goes out first.
    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] bits;
        logic [POS_BITS-1:0]   last_pos;
    } frame_load_t;

endpackage

`default_nettype wire

@@ rtl/core/lcdsw_shadow.sv @@
// Display memory shadow with read-modify-write for nibble and segment requests;
// builds the serial frame for each accepted request. Depends on lcdsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdsw_shadow (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  accept,
    input  wire logic [lcdsw_pkg::OPCODE_BITS-1:0]     opcode,
    input  wire logic [lcdsw_pkg::ADDR_BITS-1:0]       address,
    input  wire logic [lcdsw_pkg::NIB_BITS-1:0]        nibble,
    input  wire logic [lcdsw_pkg::SEG_BITS-1:0]        segment,
    input  wire logic [lcdsw_pkg::COM_BITS-1:0]        common,
    input  wire logic                                  turn_on,
    input  wire logic [lcdsw_pkg::CMD_BITS-1:0]        command_code,
    output lcdsw_pkg::frame_load_t                     load
);

    logic [lcdsw_pkg::NIB_BITS-1:0] shadow_reg [lcdsw_pkg::RAM_WORDS];

    logic                                 addr_ok;
    logic                                 seg_ok;
    logic                                 wr_en;
    logic [lcdsw_pkg::ADDR_BITS-1:0]      sel_addr;
    logic [lcdsw_pkg::SHADOW_AW-1:0]      word_idx;
    logic [lcdsw_pkg::NIB_BITS-1:0]       old_word;
    logic [lcdsw_pkg::NIB_BITS-1:0]       bit_mask;
    logic [lcdsw_pkg::NIB_BITS-1:0]       word_next;

    assign addr_ok = {1'b0, address} < 7'(lcdsw_pkg::RAM_WORDS);
    assign seg_ok  = ({1'b0, segment} < 6'(lcdsw_pkg::SEGMENTS))
                  && ({1'b0, segment} < 6'(lcdsw_pkg::RAM_WORDS))
                  && ({1'b0, common} < 4'(lcdsw_pkg::COMMONS));

    assign sel_addr = (opcode == lcdsw_pkg::OP_SEGMENT) ? {1'b0, segment} : address;
    assign word_idx = sel_addr[lcdsw_pkg::SHADOW_AW-1:0];
    assign old_word = shadow_reg[word_idx];
    assign bit_mask = lcdsw_pkg::NIB_BITS'(1) << common[1:0];

    always_comb begin
        wr_en     = 1'b0;
        word_next = nibble;
        load      = '0;
        case (opcode)
            lcdsw_pkg::OP_WRITE_NIBBLE: begin
                wr_en     = accept && addr_ok;
                word_next = nibble;
            end
            lcdsw_pkg::OP_SEGMENT: begin
                wr_en     = accept && seg_ok;
                word_next = turn_on ? (old_word | bit_mask) : (old_word & ~bit_mask);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase

        if (opcode == lcdsw_pkg::OP_COMMAND) begin
            load.valid    = accept;
            load.last_pos = lcdsw_pkg::CMD_LAST;
            for (int i = 0; i < lcdsw_pkg::ID_BITS; i++) begin
                load.bits[i] = lcdsw_pkg::ID_CMD[lcdsw_pkg::ID_BITS-1-i];
            end
            for (int i = 0; i < lcdsw_pkg::CMD_BITS; i++) begin
                load.bits[lcdsw_pkg::ID_BITS+i] = command_code[lcdsw_pkg::CMD_BITS-1-i];
            end
        end else begin
            // Write frame: address goes MSB first, data LSB first.
            load.valid    = wr_en;
            load.last_pos = lcdsw_pkg::WRITE_LAST;
            for (int i = 0; i < lcdsw_pkg::ID_BITS; i++) begin
                load.bits[i] = lcdsw_pkg::ID_WRITE[lcdsw_pkg::ID_BITS-1-i];
            end
            for (int i = 0; i < lcdsw_pkg::ADDR_BITS; i++) begin
                load.bits[lcdsw_pkg::ID_BITS+i] = sel_addr[lcdsw_pkg::ADDR_BITS-1-i];
            end
            for (int i = 0; i < lcdsw_pkg::NIB_BITS; i++) begin
                load.bits[lcdsw_pkg::ID_BITS+lcdsw_pkg::ADDR_BITS+i] = word_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lcdsw_pkg::RAM_WORDS; i++) begin
                shadow_reg[i] <= '0;
            end
        end else if (wr_en) begin
            shadow_reg[word_idx] <= word_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lcdsw_serializer.sv @@
// Frame shift register that sends one bit per cycle into a registered output
// stage with backpressure. Depends on lcdsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdsw_serializer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire lcdsw_pkg::frame_load_t             load,
    output logic                                    load_ready,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic                                    m_serial_bit,
    output logic [lcdsw_pkg::POS_BITS-1:0]          m_bit_position,
    output logic                                    m_tlast
);

    logic                                 busy_reg, busy_next;
    logic [lcdsw_pkg::FRAME_BITS-1:0]     shift_reg, shift_next;
    logic [lcdsw_pkg::POS_BITS-1:0]       pos_reg, pos_next;
    logic [lcdsw_pkg::POS_BITS-1:0]       last_reg, last_next;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_bit_reg, out_bit_next;
    logic [lcdsw_pkg::POS_BITS-1:0]       out_pos_reg, out_pos_next;
    logic                                 out_last_reg, out_last_next;
    logic                                 out_free;
    logic                                 on_last;

    assign out_free   = !out_valid_reg || m_tready;
    assign on_last    = (pos_reg == last_reg);
    // A new request may load while the last bit of the current frame moves out.
    assign load_ready = !busy_reg || (on_last && out_free);

    always_comb begin
        busy_next      = busy_reg;
        shift_next     = shift_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        if (busy_reg && out_free) begin
            out_valid_next = 1'b1;
            out_bit_next   = shift_reg[0];
            out_pos_next   = pos_reg;
            out_last_next  = on_last;
            shift_next     = shift_reg >> 1;
            pos_next       = pos_reg + 1'b1;
            if (on_last) begin
                busy_next = 1'b0;
            end
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end

        if (load.valid) begin
            busy_next  = 1'b1;
            shift_next = load.bits;
            pos_next   = '0;
            last_next  = load.last_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
        shift_reg    <= shift_next;
        pos_reg      <= pos_next;
        last_reg     <= last_next;
        out_bit_reg  <= out_bit_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid       = out_valid_reg;
    assign m_serial_bit   = out_bit_reg;
    assign m_bit_position = out_pos_reg;
    assign m_tlast        = out_last_reg;

    // A load never cuts into a frame that still has bits to send.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load.valid |-> (!busy_reg || (on_last && out_free)))
        else $error("frame loaded while serializer busy");

    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load.valid |=> busy_reg)
        else $error("serializer not busy after load");

    // Every frame starts with ID bit 1 and ends on bit 11 or 12.
    a_first_bit_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_pos_reg == '0) |-> out_bit_reg)
        else $error("frame does not start with ID bit one");

    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |->
            (out_pos_reg == lcdsw_pkg::WRITE_LAST || out_pos_reg == lcdsw_pkg::CMD_LAST))
        else $error("frame ends at wrong bit position");

endmodule

`default_nettype wire

@@ rtl/core/lcd_segment_serial_writer.sv @@
// Top level of the segment LCD serial writer: stream ports, shadow stage and
// serializer. Depends on lcdsw_pkg, lcdsw_shadow and lcdsw_serializer.
`timescale 1ns / 1ps
`default_nettype none

// Each request is a nibble write, a segment bit set or clear, or a command.
// Writes update a 32-word shadow of the display memory (cleared by reset) and
// send a 13-bit write frame; commands send a 12-bit command frame. The frame
// leaves one bit per output request, each with its position and tlast on the
// final bit. A write or command request occupies the input while the frame shift
// register sends its frame, one bit per cycle while the output is not stalled; the
// next request is taken in the cycle the last bit moves to the output
// register. Requests out of range, and opcode 3, are accepted without
// occupying the input and send nothing.
module lcd_segment_serial_writer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // address[5:0], nibble[9:6], segment[14:10], common[17:15], turn_on[18],
    // command_code[27:19], zeros above.
    input  wire logic [31:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // serial_bit[0], bit_position[4:1], zeros above.
    output logic [7:0]       m_tdata,
    // frame_end
    output logic             m_tlast
);

    lcdsw_pkg::frame_load_t             load;
    logic                               accept;
    logic                               serial_bit;
    logic [lcdsw_pkg::POS_BITS-1:0]     bit_position;

    assign accept = s_tvalid && s_tready;

    lcdsw_shadow u_shadow (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .opcode       (s_tuser),
        .address      (s_tdata[5:0]),
        .nibble       (s_tdata[9:6]),
        .segment      (s_tdata[14:10]),
        .common       (s_tdata[17:15]),
        .turn_on      (s_tdata[18]),
        .command_code (s_tdata[27:19]),
        .load         (load)
    );

    lcdsw_serializer u_serializer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .load_ready     (s_tready),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_serial_bit   (serial_bit),
        .m_bit_position (bit_position),
        .m_tlast        (m_tlast)
    );

    assign m_tdata = {3'b000, bit_position, serial_bit};

endmodule

`default_nettype wire
